// ----- hdl/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, constants and character-class helpers for the string escape
// decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int CHAR_BITS = 16;

  localparam logic [15:0] CH_BACKSLASH = 16'h005C;
  localparam logic [15:0] CH_X         = 16'h0078;
  localparam logic [15:0] CH_ZERO      = 16'h0030;

  // Decoder mode codes
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_HEX0    = 3'd2,
    MODE_HEXRUN  = 3'd3,
    MODE_OCT     = 3'd4
  } sed_mode_t;

  // One result beat
  typedef struct packed {
    logic [15:0] code;
    logic        valid;
    logic        str_end;
    logic        run_last;
  } sed_res_t;

  // Decoder outputs for one input character
  typedef struct packed {
    sed_res_t             res0;
    sed_res_t             res1;
    logic [1:0]           cnt;
    sed_mode_t            mode;
    logic [CHAR_BITS-1:0] val;
  } sed_dec_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] val;
  } sed_dig_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] code;
  } sed_esc_t;

  // Map a hex digit character to its value
  function automatic sed_dig_t hex_digit(input logic [15:0] c);
    sed_dig_t d;
    d.hit = 1'b1;
    d.val = 4'd0;
    if (c inside {[16'h0030:16'h0039]}) begin
      d.val = 4'(c - 16'h0030);
    end else if (c inside {[16'h0041:16'h0046]}) begin
      d.val = 4'(c - 16'h0041 + 16'd10);
    end else if (c inside {[16'h0061:16'h0066]}) begin
      d.val = 4'(c - 16'h0061 + 16'd10);
    end else begin
      d.hit = 1'b0;
    end
    return d;
  endfunction

  function automatic logic is_octal(input logic [15:0] c);
    return (c inside {[16'h0030:16'h0037]});
  endfunction

  // Simple escape letter table
  function automatic sed_esc_t esc_lookup(input logic [15:0] c);
    sed_esc_t e;
    e.hit = 1'b1;
    case (c)
      16'h0061: e.code = 8'h07;  // a
      16'h0062: e.code = 8'h08;  // b
      16'h0066: e.code = 8'h0C;  // f
      16'h006E: e.code = 8'h0A;  // n
      16'h0072: e.code = 8'h0D;  // r
      16'h0074: e.code = 8'h09;  // t
      16'h0076: e.code = 8'h0B;  // v
      16'h0022: e.code = 8'h22;  // double quote
      16'h003F: e.code = 8'h3F;  // question mark
      16'h0027: e.code = 8'h27;  // single quote
      16'h005C: e.code = 8'h5C;  // backslash
      default: begin
        e.hit  = 1'b0;
        e.code = 8'h00;
      end
    endcase
    return e;
  endfunction

endpackage

// ----- hdl/sed_decode.sv -----
// ----------------------------------------------------------------------------
// sed_decode
// Next-state and result logic for one character: mode machine, run
// accumulator and up to two result beats.
// ----------------------------------------------------------------------------
module sed_decode (
  input  logic [15:0]                     char_code,
  input  logic                            last_char,
  input  sed_pkg::sed_mode_t              mode,
  input  logic [sed_pkg::CHAR_BITS-1:0]   val,
  output sed_pkg::sed_dec_t               dec
);
  import sed_pkg::*;

  sed_res_t             res [2];
  logic [1:0]           n;
  sed_mode_t            mode_n;
  logic [CHAR_BITS-1:0] val_n;
  logic                 do_plain;
  sed_dig_t             hd;
  sed_esc_t             es;
  logic                 oct;

  assign hd  = hex_digit(char_code);
  assign es  = esc_lookup(char_code);
  assign oct = is_octal(char_code);

  always_comb begin
    res[0]   = '0;
    res[1]   = '0;
    n        = 2'd0;
    mode_n   = mode;
    val_n    = val;
    do_plain = 1'b0;

    // Advance the mode machine
    case (mode)
      MODE_ESC: begin
        if (es.hit) begin
          res[0] = '{code: {8'h00, es.code}, valid: 1'b1, str_end: 1'b0, run_last: 1'b0};
          n      = 2'd1;
          mode_n = MODE_NORMAL;
        end else if (char_code == CH_X) begin
          val_n  = '0;
          mode_n = MODE_HEX0;
        end else if (oct) begin
          val_n  = CHAR_BITS'(char_code[2:0]);
          mode_n = MODE_OCT;
        end else begin
          mode_n = MODE_NORMAL;
        end
      end
      MODE_HEX0: begin
        if (hd.hit) begin
          val_n  = CHAR_BITS'(hd.val);
          mode_n = MODE_HEXRUN;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_HEXRUN: begin
        if (hd.hit) begin
          val_n = {val[CHAR_BITS-5:0], hd.val};
        end else begin
          res[0]   = '{code: 16'(val), valid: 1'b1, str_end: 1'b0, run_last: 1'b0};
          n        = 2'd1;
          do_plain = 1'b1;
        end
      end
      MODE_OCT: begin
        if (oct) begin
          val_n = {val[CHAR_BITS-4:0], char_code[2:0]};
        end else begin
          res[0]   = '{code: 16'(val), valid: 1'b1, str_end: 1'b0, run_last: 1'b0};
          n        = 2'd1;
          do_plain = 1'b1;
        end
      end
      default: begin
        do_plain = 1'b1;
      end
    endcase

    // Handle the character as plain input
    if (do_plain) begin
      if (char_code == CH_BACKSLASH) begin
        mode_n = MODE_ESC;
      end else begin
        mode_n      = MODE_NORMAL;
        res[n[0]]   = '{code: char_code, valid: 1'b1, str_end: 1'b0, run_last: 1'b0};
        n           = n + 2'd1;
      end
    end

    // Close the string: flush an open run, or emit an empty end marker
    if (last_char) begin
      if (mode_n == MODE_HEXRUN || mode_n == MODE_OCT) begin
        res[n[0]] = '{code: 16'(val_n), valid: 1'b1, str_end: 1'b0, run_last: 1'b0};
        n         = n + 2'd1;
      end
      if (n == 2'd0) begin
        n = 2'd1;
      end
      res[1'(n - 2'd1)].str_end = 1'b1;
      mode_n = MODE_NORMAL;
      val_n  = '0;
    end

    if (n != 2'd0) begin
      res[1'(n - 2'd1)].run_last = 1'b1;
    end
  end

  assign dec = '{res0: res[0], res1: res[1], cnt: n, mode: mode_n, val: val_n};

endmodule

// ----- hdl/string_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// string_escape_decoder
// Backslash-escape decoder for a stream of 16-bit character codes.
// ----------------------------------------------------------------------------
// Output: the result beats of an accepted character are registered and presented
// the cycle after. Throughput: one character per cycle while the receiver takes
// beats; a character that yields two results fills the two-entry result buffer, and so holds the input.
// Reset: rst_n synchronous active low; mode returns to normal, accumulator
// clears, result buffer empties.
module string_escape_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] char_code
  input  logic        in_tlast,   // last_char
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] out_code
  output logic [1:0]  out_tuser,  // [0] char_valid, [1] run_last
  output logic        out_tlast   // string_end
);
  import sed_pkg::*;

  sed_mode_t            mode_r, mode_nxt;
  logic [CHAR_BITS-1:0] val_r, val_nxt;
  sed_res_t             q_r [2];
  logic [1:0]           cnt_r, cnt_nxt;
  sed_dec_t             dec;
  logic                 push, pop;

  sed_decode u_dec (
    .char_code (in_tdata),
    .last_char (in_tlast),
    .mode      (mode_r),
    .val       (val_r),
    .dec       (dec)
  );

  // Accept when the buffer is empty or drains empty this cycle
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign push       = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;

  assign out_tdata  = q_r[0].code;
  assign out_tuser  = {q_r[0].run_last, q_r[0].valid};
  assign out_tlast  = q_r[0].str_end;

  always_comb begin
    mode_nxt = mode_r;
    val_nxt  = val_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      mode_nxt = dec.mode;
      val_nxt  = dec.val;
      cnt_nxt  = dec.cnt;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      val_r  <= '0;
      cnt_r  <= 2'd0;
    end else begin
      mode_r <= mode_nxt;
      val_r  <= val_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Load new results, or shift the buffer on a drained beat
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[0] <= dec.res0;
      q_r[1] <= dec.res1;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
  end

  // Assertions
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[1])
    else $error("string end without run_last");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> (q_r[1].run_last && !q_r[0].run_last && q_r[0].valid))
    else $error("two-beat result malformed");

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (push && in_tlast) |=> (mode_r == MODE_NORMAL && val_r == '0))
    else $error("state not cleared after string end");

endmodule

// ----- tb/tb_string_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// tb_string_escape_decoder
// Self-checking bench for the backslash-escape decoder. A directed table of
// characters opens the run, then random strings built from plain text, simple
// escapes, hex and octal runs, unknown escapes and noise follow under several
// idle and stall patterns. Every accepted character goes through a local
// decoder model, and each output beat is checked against the oldest pending
// result.
// ----------------------------------------------------------------------------
module tb_string_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import sed_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int PHASE_CHARS     = 100;
  localparam int DIR_ROWS        = 26;
  localparam sed_res_t NO_RES    = '0;

  // One directed row: character, end flag, and a typed result if obvious
  typedef struct packed {
    logic [15:0] ch;
    logic        last;
    logic        typed;
    sed_res_t    res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] char_code
  logic        in_tlast = 1'b0; // last_char
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] out_code
  logic [1:0]  out_tuser;       // [0] char_valid, [1] run_last
  logic        out_tlast;       // string_end

  // Decoder model state
  sed_mode_t   dec_mode = MODE_NORMAL;
  logic [15:0] esc_acc = '0;
  sed_res_t    pred_res [2];
  int          pred_n;
  sed_res_t    decoded_q [$];

  // Escape letters and the codes they stand for
  byte esc_from [11] = '{8'h61, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74, 8'h76,
                         8'h22, 8'h3F, 8'h27, 8'h5C};
  byte esc_to   [11] = '{8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B,
                         8'h22, 8'h3F, 8'h27, 8'h5C};

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int n_chars = 0;
  int n_results = 0;
  int n_errors = 0;
  int idle_cycles = 0;

  sed_res_t got_beat;
  sed_res_t want_beat;

  // Directed characters; typed results only where the answer is plain
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{16'h0041, 1'b0, 1'b1, '{16'h0041, 1'b1, 1'b0, 1'b1}},  // plain A
    '{16'h0000, 1'b0, 1'b1, '{16'h0000, 1'b1, 1'b0, 1'b1}},  // lowest code
    '{16'hFFFF, 1'b0, 1'b1, '{16'hFFFF, 1'b1, 1'b0, 1'b1}},  // highest code
    '{16'h005C, 1'b0, 1'b0, NO_RES},
    '{16'h006E, 1'b0, 1'b1, '{16'h000A, 1'b1, 1'b0, 1'b1}},  // \n
    '{16'h005C, 1'b0, 1'b0, NO_RES},
    '{16'h0071, 1'b0, 1'b0, NO_RES},                          // unknown \q
    '{16'h0042, 1'b0, 1'b1, '{16'h0042, 1'b1, 1'b0, 1'b1}},  // B survives
    '{16'h005C, 1'b0, 1'b0, NO_RES},
    '{16'h0078, 1'b0, 1'b0, NO_RES},
    '{16'h0047, 1'b0, 1'b1, '{16'h0047, 1'b1, 1'b0, 1'b1}},  // \x then G
    '{16'h005C, 1'b0, 1'b0, NO_RES},
    '{16'h0078, 1'b0, 1'b0, NO_RES},
    '{16'h0046, 1'b0, 1'b0, NO_RES},
    '{16'h0066, 1'b0, 1'b0, NO_RES},
    '{16'h0061, 1'b0, 1'b0, NO_RES},
    '{16'h0039, 1'b0, 1'b0, NO_RES},
    '{16'h0065, 1'b0, 1'b0, NO_RES},                          // hex wraps
    '{16'h005C, 1'b0, 1'b0, NO_RES},                          // ends hex run
    '{16'h0022, 1'b0, 1'b0, NO_RES},
    '{16'h005C, 1'b0, 1'b0, NO_RES},
    '{16'h0037, 1'b0, 1'b0, NO_RES},
    '{16'h0037, 1'b0, 1'b0, NO_RES},
    '{16'h0038, 1'b0, 1'b0, NO_RES},                          // ends octal run
    '{16'h005C, 1'b1, 1'b1, '{16'h0000, 1'b0, 1'b1, 1'b1}},  // dangling \ at end
    '{16'h0051, 1'b1, 1'b1, '{16'h0051, 1'b1, 1'b1, 1'b1}}   // Q at end
  };

  string_escape_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #1 clk = ~clk;

  // Value of a hex digit character, -1 if it is not one
  function automatic int hex_value(input logic [15:0] c);
    if (c >= 16'h0030 && c <= 16'h0039) return int'(c) - 'h30;
    if (c >= 16'h0041 && c <= 16'h0046) return int'(c) - 'h41 + 10;
    if (c >= 16'h0061 && c <= 16'h0066) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic logic octal_char(input logic [15:0] c);
    return (c >= CH_ZERO) && (c <= CH_ZERO + 16'd7);
  endfunction

  function automatic void push_result(input logic [15:0] code, input logic valid);
    pred_res[pred_n] = '{code, valid, 1'b0, 1'b0};
    pred_n++;
  endfunction

  // Advance the decoder model by one character, leaving its results in pred_res
  task automatic predict_char(input logic [15:0] c, input logic last);
    int       hv;
    int       k;
    logic     hit;
    logic [7:0] tgt;
    logic     as_plain;
    pred_n = 0;
    as_plain = 1'b0;
    hit = 1'b0;
    tgt = 8'h00;
    hv = hex_value(c);
    for (k = 0; k < 11; k++) begin
      if (c == {8'h00, esc_from[k]}) begin
        hit = 1'b1;
        tgt = esc_to[k];
      end
    end
    case (dec_mode)
      MODE_ESC: begin
        if (hit) begin
          push_result({8'h00, tgt}, 1'b1);
          dec_mode = MODE_NORMAL;
        end else if (c == CH_X) begin
          esc_acc = '0;
          dec_mode = MODE_HEX0;
        end else if (octal_char(c)) begin
          esc_acc = c - CH_ZERO;
          dec_mode = MODE_OCT;
        end else begin
          // drop the unknown letter only
          dec_mode = MODE_NORMAL;
        end
      end
      MODE_HEX0: begin
        if (hv >= 0) begin
          esc_acc = 16'(hv);
          dec_mode = MODE_HEXRUN;
        end else begin
          as_plain = 1'b1;
        end
      end
      MODE_HEXRUN: begin
        if (hv >= 0) begin
          esc_acc = (esc_acc << 4) + 16'(hv);
        end else begin
          push_result(esc_acc, 1'b1);
          as_plain = 1'b1;
        end
      end
      MODE_OCT: begin
        if (octal_char(c)) begin
          esc_acc = (esc_acc << 3) + (c - CH_ZERO);
        end else begin
          push_result(esc_acc, 1'b1);
          as_plain = 1'b1;
        end
      end
      default: as_plain = 1'b1;
    endcase
    // Handle the character as ordinary input
    if (as_plain) begin
      if (c == CH_BACKSLASH) begin
        dec_mode = MODE_ESC;
      end else begin
        dec_mode = MODE_NORMAL;
        push_result(c, 1'b1);
      end
    end
    // Close the string: flush an open run, mark the final beat
    if (last) begin
      if (dec_mode == MODE_HEXRUN || dec_mode == MODE_OCT) push_result(esc_acc, 1'b1);
      if (pred_n == 0) push_result(16'h0000, 1'b0);
      pred_res[pred_n-1].str_end = 1'b1;
      dec_mode = MODE_NORMAL;
      esc_acc = '0;
    end
    if (pred_n > 0) pred_res[pred_n-1].run_last = 1'b1;
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_errors++;
  endtask

  // Offer one character beat, wait for it to be taken, record its results
  task automatic send_char(input logic [15:0] c, input logic last, input logic typed,
                           input sed_res_t want);
    int k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_char(c, last);
    if (typed) begin
      decoded_q.push_back(want);
    end else begin
      for (k = 0; k < pred_n; k++) decoded_q.push_back(pred_res[k]);
    end
    n_chars++;
    @(negedge clk);
  endtask

  // Send one random token of the escaped string, ending the string now and then
  task automatic send_token();
    logic [15:0] seq [$];
    int          kind;
    int          len;
    int          k;
    string       hexd = "0123456789abcdefABCDEF";
    string       escl = "abfnrtv\"?'\\";
    kind = $urandom_range(99);
    if (kind < 25) begin
      seq.push_back(($urandom_range(2) == 0) ? 16'($urandom) : 16'($urandom_range(32, 126)));
    end else if (kind < 45) begin
      seq.push_back(CH_BACKSLASH);
      seq.push_back(16'(escl[$urandom_range(10)]));
    end else if (kind < 65) begin
      seq.push_back(CH_BACKSLASH);
      seq.push_back(CH_X);
      len = $urandom_range(6);
      for (k = 0; k < len; k++) seq.push_back(16'(hexd[$urandom_range(21)]));
    end else if (kind < 82) begin
      seq.push_back(CH_BACKSLASH);
      len = $urandom_range(1, 7);
      for (k = 0; k < len; k++) seq.push_back(CH_ZERO + 16'($urandom_range(7)));
    end else if (kind < 90) begin
      seq.push_back(CH_BACKSLASH);
      seq.push_back(($urandom_range(1) == 0) ? 16'($urandom) : 16'($urandom_range(32, 126)));
    end else begin
      len = $urandom_range(1, 3);
      for (k = 0; k < len; k++) seq.push_back(16'($urandom));
    end
    foreach (seq[idx]) send_char(seq[idx], ($urandom_range(11) == 0), 1'b0, NO_RES);
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        out_tready <= 1'b0;
        repeat (hold_req - 1) @(negedge clk);
        hold_req = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each result beat against the oldest pending result
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = '{out_tdata, out_tuser[0], out_tlast, out_tuser[1]};
      n_results++;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat code %h", got_beat.code));
      end else begin
        want_beat = decoded_q.pop_front();
        if (got_beat.code !== want_beat.code)
          report_mismatch($sformatf("out_code %h, want %h", got_beat.code, want_beat.code));
        if (got_beat.valid !== want_beat.valid)
          report_mismatch($sformatf("char_valid %b, want %b", got_beat.valid, want_beat.valid));
        if (got_beat.str_end !== want_beat.str_end)
          report_mismatch($sformatf("string_end %b, want %b", got_beat.str_end,
                                    want_beat.str_end));
        if (got_beat.run_last !== want_beat.run_last)
          report_mismatch($sformatf("run_last %b, want %b", got_beat.run_last,
                                    want_beat.run_last));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin
    while (idle_cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TIMEOUT: no beat for %0d cycles", WATCHDOG_CYCLES);
    $display("Some tests failed");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    int i;
    int ph;
    int target;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].res);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct = 14;
          recv_stall_pct = 14;
        end
      endcase
      target = n_chars + PHASE_CHARS;
      while (n_chars < target) send_token();
    end
    in_tvalid <= 1'b0;

    // Drain, then allow a few more cycles for stray beats
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (decoded_q.size() != 0) report_mismatch("results still pending at end");

    $display("Decoded %0d characters into %0d result beats, %0d mismatches,", n_chars,
             n_results, n_errors);
    $display("over directed cases, a long output hold-off and three idle/stall mixes.");
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
